FILE: design/adsp_pkg.sv
`default_nettype none

package adsp_pkg;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_INT   = 3'b010,
    PH_FRAC  = 3'b100
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MAG_W   = 64;
  localparam int unsigned FRAC_W  = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic [FRAC_W-1:0] MAX_FRAC_DIGITS = 5'd18;

  // largest accumulator that may still take a digit: (2^63 - 1) / 10
  localparam logic [MAG_W-1:0] ACC_LIMIT_Q = 64'd922337203685477580;
  // largest last digit at the limit: remainder of the positive and negative bounds
  localparam logic [3:0] POS_LAST_DIGIT = 4'd7;
  localparam logic [3:0] NEG_LAST_DIGIT = 4'd8;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic              neg;
    phase_t            phase;
    logic              seen;
    logic [FRAC_W-1:0] frac_cnt;
    status_t           err;
  } adsp_state_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] scaled_value;
    logic [FRAC_W-1:0]       frac_digits;
    logic [STAT_W-1:0]       status;
  } adsp_result_t;

  localparam adsp_state_t STATE_INIT = '{
    mag:      '0,
    neg:      1'b0,
    phase:    PH_START,
    seen:     1'b0,
    frac_cnt: '0,
    err:      ST_OK
  };

endpackage

`default_nettype wire

FILE: design/adsp_if.sv
`default_nettype none

// character channel
interface adsp_in_if;
  import adsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// result channel
interface adsp_out_if;
  import adsp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MAG_W-1:0] scaled_value;
  logic [FRAC_W-1:0]       frac_digits;
  logic [STAT_W-1:0]       status;

  modport source (output valid, output scaled_value, output frac_digits, output status,
                  input ready);
  modport sink   (input valid, input scaled_value, input frac_digits, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: design/adsp_step.sv
`default_nettype none

module adsp_step (
  input  adsp_pkg::adsp_state_t          cur,
  input  logic [adsp_pkg::CHAR_W-1:0]    char_code,
  input  logic                           is_last,
  output adsp_pkg::adsp_state_t          nxt,
  output adsp_pkg::adsp_result_t         res
);
  import adsp_pkg::*;

  logic              is_digit;
  logic [3:0]        digit;
  logic [3:0]        last_max;
  logic              dig_ovf;
  logic [MAG_W-1:0]  mag_times_ten;
  adsp_state_t       ns;
  status_t           fin_err;

  // digit decode and times-ten accumulate with overflow check
  always_comb begin
    is_digit      = char_code inside {[CH_ZERO:CH_NINE]};
    digit         = char_code[3:0];
    last_max      = cur.neg ? NEG_LAST_DIGIT : POS_LAST_DIGIT;
    dig_ovf       = (cur.mag > ACC_LIMIT_Q) ||
                    ((cur.mag == ACC_LIMIT_Q) && (digit > last_max));
    mag_times_ten = (cur.mag << 3) + (cur.mag << 1) + {{(MAG_W-4){1'b0}}, digit};
  end

  // per-character phase update, first error sticks
  always_comb begin
    ns = cur;
    if (cur.err == ST_OK) begin
      case (cur.phase)
        PH_START: begin
          if ((char_code == CH_PLUS) || (char_code == CH_MINUS)) begin
            ns.neg   = (char_code == CH_MINUS);
            ns.phase = PH_INT;
          end else if (is_digit) begin
            ns.phase = PH_INT;
            if (dig_ovf) begin
              ns.err = ST_RANGE;
            end else begin
              ns.mag  = mag_times_ten;
              ns.seen = 1'b1;
            end
          end else begin
            ns.err = ST_SYNTAX;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            if (dig_ovf) begin
              ns.err = ST_RANGE;
            end else begin
              ns.mag  = mag_times_ten;
              ns.seen = 1'b1;
            end
          end else if ((char_code == CH_DOT) && cur.seen) begin
            ns.phase = PH_FRAC;
            ns.seen  = 1'b0;
          end else begin
            ns.err = ST_SYNTAX;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (cur.frac_cnt >= MAX_FRAC_DIGITS) begin
              ns.err = ST_RANGE;
            end else if (dig_ovf) begin
              ns.err = ST_RANGE;
            end else begin
              ns.mag      = mag_times_ten;
              ns.seen     = 1'b1;
              ns.frac_cnt = cur.frac_cnt + {{(FRAC_W-1){1'b0}}, 1'b1};
            end
          end else begin
            ns.err = ST_SYNTAX;
          end
        end
        default: begin
          ns = cur;
        end
      endcase
    end
  end

  // final checks and result on the last character
  always_comb begin
    fin_err = ns.err;
    if ((ns.err == ST_OK) && ((ns.phase == PH_START) || !ns.seen)) begin
      fin_err = ST_SYNTAX;
    end
    res.status = fin_err;
    if (fin_err == ST_OK) begin
      res.scaled_value = ns.neg ? -ns.mag : ns.mag;
      res.frac_digits  = ns.frac_cnt;
    end else begin
      res.scaled_value = '0;
      res.frac_digits  = '0;
    end
    nxt = is_last ? STATE_INIT : ns;
  end

endmodule

`default_nettype wire

FILE: design/adsp_out_reg.sv
`default_nettype none

module adsp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  adsp_pkg::adsp_result_t res,
  output logic                   free,
  adsp_out_if.source             out_ch
);
  import adsp_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  adsp_result_t res_r;

  // slot is free when empty or being drained this cycle
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.scaled_value = res_r.scaled_value;
  assign out_ch.frac_digits  = res_r.frac_digits;
  assign out_ch.status       = res_r.status;

endmodule

`default_nettype wire

FILE: design/ascii_decimal_to_scaled_int_parser_top.sv
`default_nettype none

// ASCII decimal parser: takes one character per transfer on in_ch, an optional
// '+'/'-', integer digits and optionally '.' with fraction digits, and on the
// character marked is_last delivers one result on out_ch: the signed value times
// ten to the number of fraction digits, that digit count, and a status (0 ok,
// 1 invalid syntax, 2 out of range; value and count are zero unless ok). A new
// character is taken every cycle, except that a last character waits for the
// result register to drain; the rate is set by the combinational times-ten
// accumulate between the character register and the parser state register. A
// result is loaded into the result register from its last character in the
// character register, and characters keep flowing while a finished result waits.
// The parser returns to its start state after every last character.
module ascii_decimal_to_scaled_int_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  adsp_in_if.sink    in_ch,
  adsp_out_if.source out_ch
);
  import adsp_pkg::*;

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  adsp_state_t       st_r;
  adsp_state_t       st_nxt;
  adsp_result_t      res;
  logic              out_free;
  logic              advance;
  logic              in_xfer;

  // character register moves on unless a last character finds the result slot full
  assign advance     = in_valid_r && (!last_r || out_free);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // character register control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= STATE_INIT;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_ch.char_code;
      last_r <= in_ch.is_last;
    end
  end

  adsp_step u_step (
    .cur       (st_r),
    .char_code (char_r),
    .is_last   (last_r),
    .nxt       (st_nxt),
    .res       (res)
  );

  adsp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance && last_r),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/ascii_decimal_to_scaled_int_parser_top_tb.sv
`timescale 1ns / 100ps

module ascii_decimal_to_scaled_int_parser_top_tb;
  import adsp_pkg::*;

  // one directed string, with its result typed in where it is obvious
  typedef struct {
    string             text;
    bit                typed;
    logic [MAG_W-1:0]  raw;
    logic [FRAC_W-1:0] frac;
    status_t           st;
  } dir_row_t;

  logic clk;
  logic rst_n;

  adsp_in_if  in_ch ();
  adsp_out_if out_ch ();

  ascii_decimal_to_scaled_int_parser_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // parser state as the testbench sees it
  logic [MAG_W-1:0]  num_mag;
  logic              num_neg;
  phase_t            num_phase;
  logic              num_seen;
  logic [FRAC_W-1:0] num_frac;
  status_t           num_err;

  adsp_result_t number_q[$];
  byte unsigned text_q[$];
  dir_row_t     dir_rows[$];
  adsp_result_t head;
  int           mismatches;
  int           chars_sent;
  int           burst_left;
  int           rx_mode;
  int           rx_left;
  int           rx_tick;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void number_clear();
    num_mag   = '0;
    num_neg   = 1'b0;
    num_phase = PH_START;
    num_seen  = 1'b0;
    num_frac  = '0;
    num_err   = ST_OK;
  endfunction

  // times-ten accumulate with the int64 bound for the current sign
  function automatic void number_digit(input logic [3:0] d);
    logic [MAG_W-1:0] bound;
    bound = num_neg ? {1'b1, {(MAG_W-1){1'b0}}} : {1'b0, {(MAG_W-1){1'b1}}};
    if (num_mag > (bound - {60'd0, d}) / 64'd10) begin
      num_err = ST_RANGE;
    end else begin
      num_mag  = num_mag * 64'd10 + {60'd0, d};
      num_seen = 1'b1;
    end
  endfunction

  // one character in; returns 1 with the finished number on the last one
  function automatic bit number_step(input logic [7:0] c, input logic last,
                                     output adsp_result_t res);
    logic dig;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    res = '0;
    if (num_err == ST_OK) begin
      case (num_phase)
        PH_START: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            num_neg   = (c == CH_MINUS);
            num_phase = PH_INT;
          end else if (dig) begin
            num_phase = PH_INT;
            number_digit(c[3:0]);
          end else begin
            num_err = ST_SYNTAX;
          end
        end
        PH_INT: begin
          if (dig) begin
            number_digit(c[3:0]);
          end else if (c == CH_DOT && num_seen) begin
            num_phase = PH_FRAC;
            num_seen  = 1'b0;
          end else begin
            num_err = ST_SYNTAX;
          end
        end
        default: begin
          if (!dig) begin
            num_err = ST_SYNTAX;
          end else if (num_frac >= MAX_FRAC_DIGITS) begin
            num_err = ST_RANGE;
          end else begin
            number_digit(c[3:0]);
            if (num_err == ST_OK) num_frac = num_frac + 5'd1;
          end
        end
      endcase
    end
    if (!last) return 1'b0;
    // empty integer or fraction part
    if (num_err == ST_OK && (num_phase == PH_START || !num_seen)) num_err = ST_SYNTAX;
    res.status = num_err;
    if (num_err == ST_OK) begin
      res.scaled_value = num_neg ? (64'd0 - num_mag) : num_mag;
      res.frac_digits  = num_frac;
    end
    number_clear();
    return 1'b1;
  endfunction

  // sender: bursts of characters with random gaps in between
  task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                           input adsp_result_t want);
    adsp_result_t calc;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    if (number_step(c, last, calc)) number_q.push_back(typed ? want : calc);
  endtask

  task automatic send_text(input bit typed, input adsp_result_t want);
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1, typed, want);
    end
  endtask

  function automatic void add_digits(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_sign();
    case ($urandom_range(0, 2))
      1: text_q.push_back(CH_PLUS);
      2: text_q.push_back(CH_MINUS);
      default: ;
    endcase
  endfunction

  // random string: mostly well-formed, some near the bound, some broken, some noise
  function automatic void make_number();
    int    kind;
    int    first;
    int    idx;
    string bound_s;
    bound_s = "922337203685477580";
    text_q.delete();
    kind = $urandom_range(0, 19);
    if (kind < 11) begin
      add_sign();
      add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4));
      if ($urandom_range(0, 1) == 1) begin
        text_q.push_back(CH_DOT);
        add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 5));
      end
    end else if (kind < 14) begin
      // nineteen or twenty digits around 2^63, dot anywhere inside
      add_sign();
      first = text_q.size();
      for (int i = 0; i < bound_s.len(); i++) text_q.push_back(bound_s[i]);
      text_q.push_back(CH_ZERO + 8'($urandom_range(5, 9)));
      if ($urandom_range(0, 3) == 0) add_digits(1);
      if ($urandom_range(0, 1) == 1) begin
        text_q.insert($urandom_range(first + 1, text_q.size() - 1), CH_DOT);
      end
    end else if (kind < 17) begin
      // short number with one random change that usually breaks it
      add_sign();
      add_digits($urandom_range(1, 4));
      if ($urandom_range(0, 1) == 1) begin
        text_q.push_back(CH_DOT);
        add_digits($urandom_range(1, 3));
      end
      idx = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 4))
        0: text_q[idx] = 8'($urandom_range(0, 255));
        1: text_q.insert(idx, CH_DOT);
        2: text_q.insert(idx, ($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS);
        3: if (text_q.size() > 1) text_q.pop_back();
        default: begin
          text_q.delete();
          add_sign();
          if ($urandom_range(0, 1) == 1) text_q.push_back(CH_DOT);
          if (text_q.size() == 0) text_q.push_back(CH_DOT);
        end
      endcase
    end else begin
      for (int i = $urandom_range(1, 6); i > 0; i--) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // receiver: ready pattern, picked anew at random for each run
  initial begin
    out_ch.ready = 1'b0;
    rx_left = 0;
    rx_tick = 0;
    rx_mode = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (rx_tick % 5 == 0);
      endcase
    end
  end

  // result check against the oldest expected number
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (number_q.size() == 0) begin
        if (mismatches < 30) begin
          $display("%0t ns: result expected none got scaled_value %0d frac_digits %0d status %0d",
                   $time, out_ch.scaled_value, out_ch.frac_digits, out_ch.status);
        end
        mismatches++;
      end else begin
        head = number_q.pop_front();
        if (out_ch.scaled_value !== head.scaled_value) begin
          if (mismatches < 30) begin
            $display("%0t ns: scaled_value expected %0d got %0d",
                     $time, head.scaled_value, out_ch.scaled_value);
          end
          mismatches++;
        end
        if (out_ch.frac_digits !== head.frac_digits) begin
          if (mismatches < 30) begin
            $display("%0t ns: frac_digits expected %0d got %0d",
                     $time, head.frac_digits, out_ch.frac_digits);
          end
          mismatches++;
        end
        if (out_ch.status !== head.status) begin
          if (mismatches < 30) begin
            $display("%0t ns: status expected %0d got %0d",
                     $time, head.status, out_ch.status);
          end
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    adsp_result_t want;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.is_last   = 1'b0;
    rst_n           = 1'b0;
    mismatches      = 0;
    chars_sent      = 0;
    burst_left      = 0;
    number_clear();

    // extremes, sign handling, empty parts, stray characters, first error wins
    dir_rows.push_back('{"0", 1'b1, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"9223372036854775807", 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0, ST_OK});
    dir_rows.push_back('{"-9223372036854775808", 1'b1, 64'h8000_0000_0000_0000, 5'd0, ST_OK});
    dir_rows.push_back('{"9223372036854775808", 1'b1, 64'd0, 5'd0, ST_RANGE});
    dir_rows.push_back('{"-9223372036854775809", 1'b1, 64'd0, 5'd0, ST_RANGE});
    dir_rows.push_back('{"1.000000000000000001", 1'b1, 64'd1000000000000000001, 5'd18, ST_OK});
    dir_rows.push_back('{"0.0000000000000000001", 1'b1, 64'd0, 5'd0, ST_RANGE});
    dir_rows.push_back('{"-0", 1'b1, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"+", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{"-", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{".", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{"7.", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{".5", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{"1.2.3", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{"12x4", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{"+-1", 1'b1, 64'd0, 5'd0, ST_SYNTAX});
    dir_rows.push_back('{"99999999999999999999.x", 1'b1, 64'd0, 5'd0, ST_RANGE});
    dir_rows.push_back('{"-1.5", 1'b0, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"+123.456", 1'b0, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"-0.000", 1'b0, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"-922337203685477580.8", 1'b0, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"9.999999999999999999", 1'b0, 64'd0, 5'd0, ST_OK});
    dir_rows.push_back('{"0.999999999999999999", 1'b0, 64'd0, 5'd0, ST_OK});

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed strings
    foreach (dir_rows[r]) begin
      text_q.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) text_q.push_back(dir_rows[r].text[i]);
      want = '{scaled_value: dir_rows[r].raw, frac_digits: dir_rows[r].frac,
               status: dir_rows[r].st};
      send_text(dir_rows[r].typed, want);
    end

    // random strings
    want = '0;
    while (chars_sent < 1950) begin
      make_number();
      send_text(1'b0, want);
    end
    @(negedge clk) in_ch.valid <= 1'b0;

    // drain, then wait for anything unexpected
    while (number_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && number_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: ascii_decimal_to_scaled_int_parser_top.f
design/adsp_pkg.sv
design/adsp_if.sv
design/adsp_step.sv
design/adsp_out_reg.sv
design/ascii_decimal_to_scaled_int_parser_top.sv
tb/ascii_decimal_to_scaled_int_parser_top_tb.sv
